@@ design/lcd_dlr_pkg.sv @@
// shared types and constants for the dirty line refresh block
`default_nettype none

package lcd_dlr_pkg;

  localparam int unsigned PANEL_WIDTH  = 240;
  localparam int unsigned PANEL_HEIGHT = 320;
  localparam int unsigned PIXELS       = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int unsigned ADDR_W       = $clog2(PIXELS);

  localparam int unsigned OP_W   = 2;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned LINE_W = 9;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_REFRESH = 2'd1;
  localparam logic [OP_W-1:0] OP_PULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COL_CMD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_CMD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CMD = 2'd2;

  localparam logic [CMD_W-1:0] COL_CMD_RST = 8'd42;
  localparam logic [CMD_W-1:0] ROW_CMD_RST = 8'd43;
  localparam logic [CMD_W-1:0] MEM_CMD_RST = 8'd44;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
    logic [PIX_W-1:0]  pixel;
  } in_item_t;

  typedef struct packed {
    logic             data_not_command;
    logic             is_pixel_word;
    logic [PIX_W-1:0] value;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CMD_W-1:0] col_cmd;
    logic [CMD_W-1:0] row_cmd;
    logic [CMD_W-1:0] mem_cmd;
  } cmd_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT,
    ST_PREAD,
    ST_PEMIT
  } state_t;

  typedef enum logic [3:0] {
    EM_COL_CMD,
    EM_FIRST_HI,
    EM_FIRST_LO,
    EM_LAST_HI,
    EM_LAST_LO,
    EM_ROW_CMD,
    EM_ROW_HI_A,
    EM_ROW_LO_A,
    EM_ROW_HI_B,
    EM_ROW_LO_B,
    EM_MEM_CMD
  } emit_step_t;

endpackage

`default_nettype wire

@@ design/lcd_dlr_ram.sv @@
// simple dual port ram with one write port and one registered read port
`default_nettype none

module lcd_dlr_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/lcd_dlr_seq.sv @@
// sequencer with shared compare unit, span tracking and output register
`default_nettype none

module lcd_dlr_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lcd_dlr_pkg::in_item_t in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lcd_dlr_pkg::out_item_t     out_data,
  input  wire lcd_dlr_pkg::cmd_cfg_t cfg,
  output lcd_dlr_pkg::ram_wr_t       fr_wr,
  output lcd_dlr_pkg::ram_rd_t       fr_rd,
  input  wire logic [lcd_dlr_pkg::PIX_W-1:0] fr_q,
  output lcd_dlr_pkg::ram_wr_t       sh_wr,
  output lcd_dlr_pkg::ram_rd_t       sh_rd,
  input  wire logic [lcd_dlr_pkg::PIX_W-1:0] sh_q
);

  localparam logic [lcd_dlr_pkg::COL_W-1:0] X_LAST =
    lcd_dlr_pkg::COL_W'(lcd_dlr_pkg::PANEL_WIDTH - 1);
  localparam logic [lcd_dlr_pkg::ADDR_W-1:0] CLR_LAST =
    lcd_dlr_pkg::ADDR_W'(lcd_dlr_pkg::PIXELS - 1);
  localparam logic [lcd_dlr_pkg::COL_W:0] COL_LIMIT =
    (lcd_dlr_pkg::COL_W + 1)'(lcd_dlr_pkg::PANEL_WIDTH);
  localparam logic [lcd_dlr_pkg::LINE_W:0] LINE_LIMIT =
    (lcd_dlr_pkg::LINE_W + 1)'(lcd_dlr_pkg::PANEL_HEIGHT);

  lcd_dlr_pkg::state_t     state_r, state_nxt;
  lcd_dlr_pkg::emit_step_t step_r, step_nxt;
  lcd_dlr_pkg::in_item_t   item_r;
  lcd_dlr_pkg::out_item_t  out_item_r, out_item_nxt, emit_item;

  logic [lcd_dlr_pkg::ADDR_W-1:0] clr_addr_r;
  logic [lcd_dlr_pkg::ADDR_W-1:0] base_r;
  logic [lcd_dlr_pkg::ADDR_W-1:0] cmp_addr_r;
  logic [lcd_dlr_pkg::COL_W-1:0]  x_r;
  logic [lcd_dlr_pkg::COL_W-1:0]  cmp_x_r;
  logic [lcd_dlr_pkg::COL_W-1:0]  first_r;
  logic [lcd_dlr_pkg::COL_W-1:0]  last_r;
  logic                           cmp_v_r;
  logic                           any_r;
  logic                           out_valid_r, out_valid_nxt;

  logic                           span_pending_r;
  logic [lcd_dlr_pkg::COL_W-1:0]  span_next_r;
  logic [lcd_dlr_pkg::COL_W-1:0]  span_last_r;
  logic [lcd_dlr_pkg::LINE_W-1:0] span_row_r;

  logic                           accept;
  logic                           slot_free;
  logic                           load_out;
  logic                           diff;
  logic                           col_ok;
  logic                           line_ok;
  logic [lcd_dlr_pkg::LINE_W-1:0] mul_line;
  logic [lcd_dlr_pkg::PIX_W-1:0]  first16, last16, line16;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign diff      = cmp_v_r && (fr_q != sh_q);
  assign col_ok    = {1'b0, in_data.column} < COL_LIMIT;
  assign line_ok   = {1'b0, in_data.line} < LINE_LIMIT;
  assign mul_line  = (item_r.op == lcd_dlr_pkg::OP_PULL) ? span_row_r : item_r.line;
  assign first16   = lcd_dlr_pkg::PIX_W'(first_r);
  assign last16    = lcd_dlr_pkg::PIX_W'(last_r);
  assign line16    = lcd_dlr_pkg::PIX_W'(item_r.line);

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcd_dlr_pkg::ST_CLEAR: begin
        if (clr_addr_r == CLR_LAST) state_nxt = lcd_dlr_pkg::ST_IDLE;
      end
      lcd_dlr_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (in_data.op == lcd_dlr_pkg::OP_WRITE) begin
            if (col_ok && line_ok) state_nxt = lcd_dlr_pkg::ST_BASE;
          end else if (in_data.op == lcd_dlr_pkg::OP_REFRESH) begin
            if (line_ok) state_nxt = lcd_dlr_pkg::ST_BASE;
          end else if (in_data.op == lcd_dlr_pkg::OP_PULL) begin
            if (span_pending_r) state_nxt = lcd_dlr_pkg::ST_BASE;
          end else begin
            state_nxt = lcd_dlr_pkg::ST_IDLE;
          end
        end
      end
      lcd_dlr_pkg::ST_BASE: begin
        priority if (item_r.op == lcd_dlr_pkg::OP_WRITE) state_nxt = lcd_dlr_pkg::ST_WRITE;
        else if (item_r.op == lcd_dlr_pkg::OP_REFRESH) state_nxt = lcd_dlr_pkg::ST_SCAN;
        else state_nxt = lcd_dlr_pkg::ST_PREAD;
      end
      lcd_dlr_pkg::ST_WRITE:  state_nxt = lcd_dlr_pkg::ST_IDLE;
      lcd_dlr_pkg::ST_SCAN: begin
        if (x_r == X_LAST) state_nxt = lcd_dlr_pkg::ST_DRAIN;
      end
      lcd_dlr_pkg::ST_DRAIN:  state_nxt = lcd_dlr_pkg::ST_DECIDE;
      lcd_dlr_pkg::ST_DECIDE: begin
        state_nxt = any_r ? lcd_dlr_pkg::ST_EMIT : lcd_dlr_pkg::ST_IDLE;
      end
      lcd_dlr_pkg::ST_EMIT: begin
        if (slot_free && step_r == lcd_dlr_pkg::EM_MEM_CMD) state_nxt = lcd_dlr_pkg::ST_IDLE;
      end
      lcd_dlr_pkg::ST_PREAD:  state_nxt = lcd_dlr_pkg::ST_PEMIT;
      lcd_dlr_pkg::ST_PEMIT: begin
        if (slot_free) state_nxt = lcd_dlr_pkg::ST_IDLE;
      end
      default:                state_nxt = lcd_dlr_pkg::ST_IDLE;
    endcase
  end

  // window sequence bytes
  always_comb begin
    emit_item = '0;
    unique case (step_r)
      lcd_dlr_pkg::EM_COL_CMD:  emit_item.value = {8'h00, cfg.col_cmd};
      lcd_dlr_pkg::EM_FIRST_HI: emit_item.value = {8'h00, first16[15:8]};
      lcd_dlr_pkg::EM_FIRST_LO: emit_item.value = {8'h00, first16[7:0]};
      lcd_dlr_pkg::EM_LAST_HI:  emit_item.value = {8'h00, last16[15:8]};
      lcd_dlr_pkg::EM_LAST_LO:  emit_item.value = {8'h00, last16[7:0]};
      lcd_dlr_pkg::EM_ROW_CMD:  emit_item.value = {8'h00, cfg.row_cmd};
      lcd_dlr_pkg::EM_ROW_HI_A: emit_item.value = {8'h00, line16[15:8]};
      lcd_dlr_pkg::EM_ROW_LO_A: emit_item.value = {8'h00, line16[7:0]};
      lcd_dlr_pkg::EM_ROW_HI_B: emit_item.value = {8'h00, line16[15:8]};
      lcd_dlr_pkg::EM_ROW_LO_B: emit_item.value = {8'h00, line16[7:0]};
      lcd_dlr_pkg::EM_MEM_CMD:  emit_item.value = {8'h00, cfg.mem_cmd};
      default:                  emit_item.value = '0;
    endcase
    emit_item.data_not_command = !(step_r == lcd_dlr_pkg::EM_COL_CMD ||
                                   step_r == lcd_dlr_pkg::EM_ROW_CMD ||
                                   step_r == lcd_dlr_pkg::EM_MEM_CMD);
    emit_item.last_of_run = (step_r == lcd_dlr_pkg::EM_MEM_CMD);
  end

  // outputs and ram control
  always_comb begin
    in_ready      = (state_r == lcd_dlr_pkg::ST_IDLE);
    load_out      = 1'b0;
    out_item_nxt  = out_item_r;
    step_nxt      = step_r;
    fr_wr         = '0;
    fr_rd         = '0;
    sh_wr         = '0;
    sh_rd         = '0;

    unique case (state_r)
      lcd_dlr_pkg::ST_CLEAR: begin
        fr_wr.we   = 1'b1;
        fr_wr.addr = clr_addr_r;
        sh_wr.we   = 1'b1;
        sh_wr.addr = clr_addr_r;
      end
      lcd_dlr_pkg::ST_BASE: begin
        step_nxt = lcd_dlr_pkg::EM_COL_CMD;
      end
      lcd_dlr_pkg::ST_WRITE: begin
        fr_wr.we   = 1'b1;
        fr_wr.addr = base_r + lcd_dlr_pkg::ADDR_W'(item_r.column);
        fr_wr.data = item_r.pixel;
      end
      lcd_dlr_pkg::ST_EMIT: begin
        if (slot_free) begin
          load_out     = 1'b1;
          out_item_nxt = emit_item;
          step_nxt     = lcd_dlr_pkg::emit_step_t'(step_r + 4'd1);
        end
      end
      lcd_dlr_pkg::ST_PREAD: begin
        sh_rd.re   = 1'b1;
        sh_rd.addr = base_r + lcd_dlr_pkg::ADDR_W'(span_next_r);
      end
      lcd_dlr_pkg::ST_PEMIT: begin
        if (slot_free) begin
          load_out                      = 1'b1;
          out_item_nxt.data_not_command = 1'b1;
          out_item_nxt.is_pixel_word    = 1'b1;
          out_item_nxt.value            = sh_q;
          out_item_nxt.last_of_run      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // scan: read both stores ahead, write back in the cycle after the read
    if (state_r == lcd_dlr_pkg::ST_SCAN) begin
      fr_rd.re   = 1'b1;
      fr_rd.addr = base_r + lcd_dlr_pkg::ADDR_W'(x_r);
      sh_rd.re   = 1'b1;
      sh_rd.addr = base_r + lcd_dlr_pkg::ADDR_W'(x_r);
    end
    if (state_r != lcd_dlr_pkg::ST_CLEAR && diff) begin
      sh_wr.we   = 1'b1;
      sh_wr.addr = cmp_addr_r;
      sh_wr.data = fr_q;
    end

    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_ready);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lcd_dlr_pkg::ST_CLEAR;
      step_r         <= lcd_dlr_pkg::EM_COL_CMD;
      clr_addr_r     <= '0;
      cmp_v_r        <= 1'b0;
      any_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      span_pending_r <= 1'b0;
      span_next_r    <= '0;
      span_last_r    <= '0;
      span_row_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= (state_r == lcd_dlr_pkg::ST_SCAN);
      if (state_r == lcd_dlr_pkg::ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (state_r == lcd_dlr_pkg::ST_BASE) begin
        any_r <= 1'b0;
      end else if (diff) begin
        any_r <= 1'b1;
      end
      if (state_r == lcd_dlr_pkg::ST_DECIDE && any_r) begin
        span_pending_r <= 1'b1;
        span_next_r    <= first_r;
        span_last_r    <= last_r;
        span_row_r     <= item_r.line;
      end
      if (state_r == lcd_dlr_pkg::ST_PEMIT && slot_free) begin
        if (span_next_r >= span_last_r) span_pending_r <= 1'b0;
        else span_next_r <= span_next_r + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (state_r == lcd_dlr_pkg::ST_BASE) begin
      base_r <= lcd_dlr_pkg::ADDR_W'(mul_line) *
                lcd_dlr_pkg::ADDR_W'(lcd_dlr_pkg::PANEL_WIDTH);
      x_r    <= '0;
    end else if (state_r == lcd_dlr_pkg::ST_SCAN) begin
      x_r <= x_r + 1'b1;
    end
    cmp_x_r    <= x_r;
    cmp_addr_r <= base_r + lcd_dlr_pkg::ADDR_W'(x_r);
    if (diff) begin
      if (!any_r) first_r <= cmp_x_r;
      last_r <= cmp_x_r;
    end
    if (load_out) out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

@@ design/lcd_dirty_line_refresh.sv @@
// pixel write: stored in the WRITE state after BASE, in_ready back then
// pull: pixel word loaded into the output register in PEMIT, after BASE and PREAD
// refresh: compare pass over the panel width, then DRAIN and DECIDE; if any pixel
// differs, 11 results at one per cycle without stalls
// transactions: one at a time; refresh bounded by the compare pass over the line
// reset: synchronous, active low; both stores cleared one address per cycle, all 76800
`default_nettype none

module lcd_dirty_line_refresh (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lcd_dlr_pkg::in_item_t in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lcd_dlr_pkg::out_item_t     out_data,
  input  wire logic                  cfg_we,
  input  wire logic [lcd_dlr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lcd_dlr_pkg::CMD_W-1:0]     cfg_data
);

  lcd_dlr_pkg::cmd_cfg_t cfg_r;
  lcd_dlr_pkg::ram_wr_t  fr_wr, sh_wr;
  lcd_dlr_pkg::ram_rd_t  fr_rd, sh_rd;
  logic [lcd_dlr_pkg::PIX_W-1:0] fr_q, sh_q;

  // command registers return to 42, 43, 44 at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col_cmd <= lcd_dlr_pkg::COL_CMD_RST;
      cfg_r.row_cmd <= lcd_dlr_pkg::ROW_CMD_RST;
      cfg_r.mem_cmd <= lcd_dlr_pkg::MEM_CMD_RST;
    end else if (cfg_we) begin
      priority if (cfg_index == lcd_dlr_pkg::CFG_COL_CMD) cfg_r.col_cmd <= cfg_data;
      else if (cfg_index == lcd_dlr_pkg::CFG_ROW_CMD) cfg_r.row_cmd <= cfg_data;
      else if (cfg_index == lcd_dlr_pkg::CFG_MEM_CMD) cfg_r.mem_cmd <= cfg_data;
      else cfg_r <= cfg_r;
    end
  end

  lcd_dlr_ram #(
    .DEPTH (lcd_dlr_pkg::PIXELS),
    .WIDTH (lcd_dlr_pkg::PIX_W)
  ) u_frame (
    .clk   (clk),
    .we    (fr_wr.we),
    .waddr (fr_wr.addr),
    .wdata (fr_wr.data),
    .re    (fr_rd.re),
    .raddr (fr_rd.addr),
    .rdata (fr_q)
  );

  lcd_dlr_ram #(
    .DEPTH (lcd_dlr_pkg::PIXELS),
    .WIDTH (lcd_dlr_pkg::PIX_W)
  ) u_shadow (
    .clk   (clk),
    .we    (sh_wr.we),
    .waddr (sh_wr.addr),
    .wdata (sh_wr.data),
    .re    (sh_rd.re),
    .raddr (sh_rd.addr),
    .rdata (sh_q)
  );

  lcd_dlr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg       (cfg_r),
    .fr_wr     (fr_wr),
    .fr_rd     (fr_rd),
    .fr_q      (fr_q),
    .sh_wr     (sh_wr),
    .sh_rd     (sh_rd),
    .sh_q      (sh_q)
  );

endmodule

`default_nettype wire
